// File: hw/rtl/dtf_pkg.sv
// Shared types, widths and helper functions for the detection/tracker fusion block.
// Used by every module in hw/rtl; has no dependencies of its own.
package dtf_pkg;

   localparam int COORD_BITS  = 12;
   localparam int CLASS_BITS  = 8;
   localparam int CENTER_BITS = COORD_BITS + 2;
   localparam int METRIC_BITS = 29;
   localparam int AREA_BITS   = 2 * COORD_BITS;
   localparam int SQ_BITS     = (2 * CENTER_BITS + 1 > METRIC_BITS) ?
                                (2 * CENTER_BITS + 1) : METRIC_BITS;
   localparam int OVL_BITS    = COORD_BITS + 1;
   localparam int INTER_BITS  = 2 * OVL_BITS;
   localparam int UNION_BITS  = AREA_BITS + 1;
   localparam int CMP_BITS    = AREA_BITS + 3;

   localparam logic FUNC_DETECT    = 1'b0;
   localparam logic FUNC_FRAME_END = 1'b1;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } box_type;

   typedef struct packed {
      logic                   have;
      box_type                box;
      logic [AREA_BITS-1:0]   area;
      logic [METRIC_BITS-1:0] metric;
   } cand_type;

   typedef struct packed {
      logic                   locked;
      logic [CENTER_BITS-1:0] cx;
      logic [CENTER_BITS-1:0] cy;
   } track_type;

   typedef struct packed {
      box_type roi;
      logic    success;
      logic    reinit;
   } res_type;

   function automatic logic [CENTER_BITS-1:0] center_of(input logic [COORD_BITS-1:0] pos,
                                                       input logic [COORD_BITS-1:0] len);
      return {1'b0, pos, 1'b0} + {2'b00, len};
   endfunction

endpackage

// File: hw/rtl/dtf_cand.sv
// Candidate keeper: scores each target-class detection and holds the best box of the frame.
// Depends on dtf_pkg for box, candidate and track state types.
module dtf_cand (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              det_go,
   input  logic                              clear,
   input  dtf_pkg::box_type                  box,
   input  logic [dtf_pkg::CLASS_BITS-1:0]    class_id,
   input  logic [dtf_pkg::CLASS_BITS-1:0]    target_class,
   input  dtf_pkg::track_type                track,
   output dtf_pkg::cand_type                 cand
);

   logic                                have_best_ff, have_best_in;
   dtf_pkg::box_type                    best_box_ff, best_box_in;
   logic [dtf_pkg::AREA_BITS-1:0]       best_area_ff, best_area_in;
   logic [dtf_pkg::METRIC_BITS-1:0]     best_metric_ff, best_metric_in;

   logic [dtf_pkg::CENTER_BITS-1:0]     cen_x, cen_y, dx, dy;
   logic [dtf_pkg::SQ_BITS-1:0]         dist_sq;
   logic [dtf_pkg::AREA_BITS-1:0]       area;
   logic [dtf_pkg::METRIC_BITS-1:0]     metric;
   logic                                take;

   always_comb begin
      cen_x   = dtf_pkg::center_of(box.x, box.w);
      cen_y   = dtf_pkg::center_of(box.y, box.h);
      dx      = (cen_x > track.cx) ? (cen_x - track.cx) : (track.cx - cen_x);
      dy      = (cen_y > track.cy) ? (cen_y - track.cy) : (track.cy - cen_y);
      dist_sq = dtf_pkg::SQ_BITS'(dx) * dtf_pkg::SQ_BITS'(dx) +
                dtf_pkg::SQ_BITS'(dy) * dtf_pkg::SQ_BITS'(dy);
      area    = dtf_pkg::AREA_BITS'(box.w) * dtf_pkg::AREA_BITS'(box.h);
      if (track.locked) begin
         metric = dist_sq[dtf_pkg::METRIC_BITS-1:0];
         take   = !have_best_ff || (metric < best_metric_ff);
      end else begin
         metric = dtf_pkg::METRIC_BITS'(dtf_pkg::SQ_BITS'(area));
         take   = metric > best_metric_ff;
      end
   end

   always_comb begin
      priority if (clear) begin
         have_best_in   = 1'b0;
         best_box_in    = '0;
         best_area_in   = '0;
         best_metric_in = '0;
      end else if (det_go && (class_id == target_class) && take) begin
         have_best_in   = 1'b1;
         best_box_in    = box;
         best_area_in   = area;
         best_metric_in = metric;
      end else begin
         have_best_in   = have_best_ff;
         best_box_in    = best_box_ff;
         best_area_in   = best_area_ff;
         best_metric_in = best_metric_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff   <= 1'b0;
         best_box_ff    <= '0;
         best_area_ff   <= '0;
         best_metric_ff <= '0;
      end else begin
         have_best_ff   <= have_best_in;
         best_box_ff    <= best_box_in;
         best_area_ff   <= best_area_in;
         best_metric_ff <= best_metric_in;
      end
   end

   assign cand.have   = have_best_ff;
   assign cand.box    = best_box_ff;
   assign cand.area   = best_area_ff;
   assign cand.metric = best_metric_ff;

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      clear |=> (!have_best_ff && (best_metric_ff == '0)))
      else $error("candidate not cleared at frame end");

   a_empty_metric_zero : assert property (@(posedge clock) disable iff (reset)
      !have_best_ff |-> (best_metric_ff == '0))
      else $error("metric nonzero without a candidate");

   a_unlocked_area_positive : assert property (@(posedge clock) disable iff (reset)
      (have_best_ff && !track.locked) |-> (best_metric_ff != '0))
      else $error("zero-area candidate kept while unlocked");

endmodule

// File: hw/rtl/dtf_decide.sv
// Frame-end resolver: overlap test, region choice and the lock and tracker state.
// Depends on dtf_pkg for box, candidate, track and result types.
module dtf_decide (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  dtf_pkg::box_type   box,
   input  logic               trk_valid,
   input  dtf_pkg::cand_type  cand,
   output dtf_pkg::track_type track,
   output dtf_pkg::res_type   result
);

   logic                              locked_ff, locked_in;
   logic                              started_ff, started_in;
   logic [dtf_pkg::CENTER_BITS-1:0]   cx_ff, cx_in, cy_ff, cy_in;

   logic [dtf_pkg::COORD_BITS-1:0]    lo_x, lo_y;
   logic [dtf_pkg::OVL_BITS-1:0]      ae_x, be_x, ae_y, be_y, hi_x, hi_y, ov_x, ov_y;
   logic [dtf_pkg::INTER_BITS-1:0]    inter;
   logic [dtf_pkg::AREA_BITS-1:0]     area_trk;
   logic [dtf_pkg::UNION_BITS-1:0]    uni;
   logic [dtf_pkg::CMP_BITS-1:0]      lhs, rhs;
   logic                              overlap_ok, tracker_good;
   dtf_pkg::box_type                  sel;

   always_comb begin
      lo_x  = (cand.box.x > box.x) ? cand.box.x : box.x;
      lo_y  = (cand.box.y > box.y) ? cand.box.y : box.y;
      ae_x  = {1'b0, cand.box.x} + {1'b0, cand.box.w};
      be_x  = {1'b0, box.x} + {1'b0, box.w};
      ae_y  = {1'b0, cand.box.y} + {1'b0, cand.box.h};
      be_y  = {1'b0, box.y} + {1'b0, box.h};
      hi_x  = (ae_x < be_x) ? ae_x : be_x;
      hi_y  = (ae_y < be_y) ? ae_y : be_y;
      ov_x  = (hi_x > {1'b0, lo_x}) ? (hi_x - {1'b0, lo_x}) : '0;
      ov_y  = (hi_y > {1'b0, lo_y}) ? (hi_y - {1'b0, lo_y}) : '0;
      inter = dtf_pkg::INTER_BITS'(ov_x) * dtf_pkg::INTER_BITS'(ov_y);
      area_trk = dtf_pkg::AREA_BITS'(box.w) * dtf_pkg::AREA_BITS'(box.h);
      uni   = dtf_pkg::UNION_BITS'(cand.area) + dtf_pkg::UNION_BITS'(area_trk) -
              inter[dtf_pkg::UNION_BITS-1:0];
      lhs   = (dtf_pkg::CMP_BITS'(inter) << 2) + dtf_pkg::CMP_BITS'(inter);
      rhs   = dtf_pkg::CMP_BITS'(uni) << 2;
      overlap_ok   = lhs > rhs;
      tracker_good = started_ff && trk_valid;
   end

   always_comb begin
      result.reinit  = 1'b0;
      sel            = box;
      started_in     = started_ff;
      priority if (cand.have) begin
         result.success = 1'b1;
         if (!(tracker_good && overlap_ok)) begin
            sel           = cand.box;
            result.reinit = 1'b1;
            started_in    = go | started_ff;
         end
      end else if (tracker_good) begin
         result.success = 1'b1;
      end else begin
         result.success = 1'b0;
      end
      result.roi = result.success ? sel : '0;
      locked_in  = locked_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      if (go && result.success) begin
         locked_in = 1'b1;
         cx_in     = dtf_pkg::center_of(sel.x, sel.w);
         cy_in     = dtf_pkg::center_of(sel.y, sel.h);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff  <= 1'b0;
         started_ff <= 1'b0;
         cx_ff      <= '0;
         cy_ff      <= '0;
      end else begin
         locked_ff  <= locked_in;
         started_ff <= started_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
      end
   end

   assign track.locked = locked_ff;
   assign track.cx     = cx_ff;
   assign track.cy     = cy_ff;

   a_reinit_needs_success : assert property (@(posedge clock) disable iff (reset)
      result.reinit |-> (result.success && cand.have))
      else $error("tracker restart without a detection region");

   a_success_locks : assert property (@(posedge clock) disable iff (reset)
      (go && result.success) |=> locked_ff)
      else $error("lock not taken after a produced region");

   a_started_sticky : assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("tracker started flag dropped");

endmodule

// File: hw/rtl/detection_tracker_fusion_core.sv
// Top level of the detection/tracker fusion block: request register, result register.
// Depends on dtf_pkg, dtf_cand and dtf_decide.
//
// The block takes one request per clock, with no gaps, for any mix of detection and
// frame-end requests, while no frame-end request meets a stalled response. A request is
// captured in an input register and resolved from there against the frame's candidate and
// the lock state, which are updated as it is resolved so that the next request sees them.
// Detection requests give no response; a frame-end request gives exactly one response,
// which enters the result register as it is resolved. That register decouples the sides:
// a stalled response holds the flow only once a frame-end request is in the input register.
// The target class register must be written while no request is in flight.
module detection_tracker_fusion_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [dtf_pkg::CLASS_BITS-1:0]    csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [dtf_pkg::COORD_BITS-1:0]    req_box_x,
   input  logic [dtf_pkg::COORD_BITS-1:0]    req_box_y,
   input  logic [dtf_pkg::COORD_BITS-1:0]    req_box_w,
   input  logic [dtf_pkg::COORD_BITS-1:0]    req_box_h,
   input  logic [dtf_pkg::CLASS_BITS-1:0]    req_class_id,
   input  logic                              req_trk_valid,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dtf_pkg::COORD_BITS-1:0]    rsp_roi_x,
   output logic [dtf_pkg::COORD_BITS-1:0]    rsp_roi_y,
   output logic [dtf_pkg::COORD_BITS-1:0]    rsp_roi_w,
   output logic [dtf_pkg::COORD_BITS-1:0]    rsp_roi_h,
   output logic                              rsp_success,
   output logic                              rsp_reinit_tracker
);

   logic [dtf_pkg::CLASS_BITS-1:0]   target_class_ff;
   logic                             in_vld_ff, in_vld_in;
   logic                             func_ff;
   dtf_pkg::box_type                 box_ff;
   logic [dtf_pkg::CLASS_BITS-1:0]   class_ff;
   logic                             trk_valid_ff;
   logic                             rsp_vld_ff, rsp_vld_in;
   dtf_pkg::res_type                 rsp_ff;

   logic                             req_take, out_free, proc_go, det_go, end_go;
   dtf_pkg::cand_type                cand;
   dtf_pkg::track_type               track;
   dtf_pkg::res_type                 result;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign proc_go   = in_vld_ff && ((func_ff == dtf_pkg::FUNC_DETECT) || out_free);
   assign det_go    = proc_go && (func_ff == dtf_pkg::FUNC_DETECT);
   assign end_go    = proc_go && (func_ff == dtf_pkg::FUNC_FRAME_END);
   assign req_stall = in_vld_ff && !proc_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      priority if (req_take) begin
         in_vld_in = 1'b1;
      end else if (proc_go) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
      priority if (end_go) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_class_ff <= '0;
         in_vld_ff       <= 1'b0;
         rsp_vld_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            target_class_ff <= csr_wr_data;
         end
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff      <= req_func;
         box_ff.x     <= req_box_x;
         box_ff.y     <= req_box_y;
         box_ff.w     <= req_box_w;
         box_ff.h     <= req_box_h;
         class_ff     <= req_class_id;
         trk_valid_ff <= req_trk_valid;
      end
      if (end_go) begin
         rsp_ff <= result;
      end
   end

   dtf_cand u_cand (
      .clock        (clock),
      .reset        (reset),
      .det_go       (det_go),
      .clear        (end_go),
      .box          (box_ff),
      .class_id     (class_ff),
      .target_class (target_class_ff),
      .track        (track),
      .cand         (cand)
   );

   dtf_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .go        (end_go),
      .box       (box_ff),
      .trk_valid (trk_valid_ff),
      .cand      (cand),
      .track     (track),
      .result    (result)
   );

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_roi_x          = rsp_ff.roi.x;
   assign rsp_roi_y          = rsp_ff.roi.y;
   assign rsp_roi_w          = rsp_ff.roi.w;
   assign rsp_roi_h          = rsp_ff.roi.h;
   assign rsp_success        = rsp_ff.success;
   assign rsp_reinit_tracker = rsp_ff.reinit;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for detection_tracker_fusion_core: random detection frames,
// target class changes and both-side flow control, checked against a built-in predictor.
// Depends on dtf_pkg and the detection_tracker_fusion_core RTL.
module testbench;

   localparam int MAX_COORD   = (1 << dtf_pkg::COORD_BITS) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 500;

   typedef struct packed {
      logic                           func;
      dtf_pkg::box_type               box;
      logic [dtf_pkg::CLASS_BITS-1:0] class_id;
      logic                           trk_valid;
   } detection_req_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [dtf_pkg::CLASS_BITS-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = 1'b0;
   logic [dtf_pkg::COORD_BITS-1:0] req_box_x = '0;
   logic [dtf_pkg::COORD_BITS-1:0] req_box_y = '0;
   logic [dtf_pkg::COORD_BITS-1:0] req_box_w = '0;
   logic [dtf_pkg::COORD_BITS-1:0] req_box_h = '0;
   logic [dtf_pkg::CLASS_BITS-1:0] req_class_id = '0;
   logic req_trk_valid = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [dtf_pkg::COORD_BITS-1:0] rsp_roi_x;
   logic [dtf_pkg::COORD_BITS-1:0] rsp_roi_y;
   logic [dtf_pkg::COORD_BITS-1:0] rsp_roi_w;
   logic [dtf_pkg::COORD_BITS-1:0] rsp_roi_h;
   logic rsp_success;
   logic rsp_reinit_tracker;

   detection_tracker_fusion_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_box_x          (req_box_x),
      .req_box_y          (req_box_y),
      .req_box_w          (req_box_w),
      .req_box_h          (req_box_h),
      .req_class_id       (req_class_id),
      .req_trk_valid      (req_trk_valid),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_roi_x          (rsp_roi_x),
      .rsp_roi_y          (rsp_roi_y),
      .rsp_roi_w          (rsp_roi_w),
      .rsp_roi_h          (rsp_roi_h),
      .rsp_success        (rsp_success),
      .rsp_reinit_tracker (rsp_reinit_tracker)
   );

   // Predictor state: lock, tracker status and the best candidate of the current frame.
   logic [dtf_pkg::CLASS_BITS-1:0]  watch_class = '0;
   logic [dtf_pkg::CENTER_BITS-1:0] last_cx = '0;
   logic [dtf_pkg::CENTER_BITS-1:0] last_cy = '0;
   bit                              is_locked = 1'b0;
   bit                              tracker_live = 1'b0;
   bit                              cand_valid = 1'b0;
   dtf_pkg::box_type                cand_box = '0;
   logic [dtf_pkg::METRIC_BITS-1:0] cand_metric = '0;

   dtf_pkg::res_type  expected_rois[$];
   detection_req_type request_backlog[$];
   detection_req_type drive_item = '0;

   int queued_total = 0;
   int accepted_total = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int idle_left = 0;
   int stall_mode = 0;
   int stall_mode_left = 0;
   dtf_pkg::box_type scene_box = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned span_common(input longint unsigned a0, al, b0, bl);
      longint unsigned lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic bit tracker_agrees(input dtf_pkg::box_type d,
                                         input dtf_pkg::box_type t);
      longint unsigned inter, uni, area_d, area_t;
      inter = span_common(longint'(d.x), longint'(d.w), longint'(t.x), longint'(t.w)) *
              span_common(longint'(d.y), longint'(d.h), longint'(t.y), longint'(t.h));
      area_d = longint'(d.w) * longint'(d.h);
      area_t = longint'(t.w) * longint'(t.h);
      uni = area_d + area_t - inter;
      return 5 * inter > 4 * uni;
   endfunction

   function automatic void fuse_request(input detection_req_type r);
      longint unsigned dx, dy, px, py, lx, ly;
      logic [dtf_pkg::METRIC_BITS-1:0] metric;
      bit take, good, success, reinit;
      dtf_pkg::box_type sel;
      dtf_pkg::res_type res;
      if (r.func == dtf_pkg::FUNC_DETECT) begin
         if (r.class_id != watch_class) return;
         if (is_locked) begin
            px = 2 * longint'(r.box.x) + longint'(r.box.w);
            py = 2 * longint'(r.box.y) + longint'(r.box.h);
            lx = longint'(last_cx);
            ly = longint'(last_cy);
            dx = (px > lx) ? px - lx : lx - px;
            dy = (py > ly) ? py - ly : ly - py;
            metric = dtf_pkg::METRIC_BITS'(dx * dx + dy * dy);
            take = !cand_valid || metric < cand_metric;
         end else begin
            metric = dtf_pkg::METRIC_BITS'(longint'(r.box.w) * longint'(r.box.h));
            take = metric > cand_metric;
         end
         if (take) begin
            cand_valid = 1'b1;
            cand_metric = metric;
            cand_box = r.box;
         end
         return;
      end
      good = tracker_live && r.trk_valid;
      success = 1'b0;
      reinit = 1'b0;
      sel = r.box;
      if (cand_valid) begin
         success = 1'b1;
         if (!(good && tracker_agrees(cand_box, r.box))) begin
            sel = cand_box;
            reinit = 1'b1;
            tracker_live = 1'b1;
         end
      end else if (good) begin
         success = 1'b1;
      end
      res.roi = success ? sel : '0;
      res.success = success;
      res.reinit = reinit;
      if (success) begin
         last_cx = dtf_pkg::CENTER_BITS'(2 * longint'(sel.x) + longint'(sel.w));
         last_cy = dtf_pkg::CENTER_BITS'(2 * longint'(sel.y) + longint'(sel.h));
         is_locked = 1'b1;
      end
      expected_rois.push_back(res);
      cand_valid = 1'b0;
      cand_metric = '0;
      cand_box = '0;
   endfunction

   function automatic logic [dtf_pkg::COORD_BITS-1:0] shift_coord(
         input logic [dtf_pkg::COORD_BITS-1:0] v, input int amt);
      int s;
      s = int'(v) + int'($urandom_range(0, 2 * amt)) - amt;
      if (s < 0) s = 0;
      if (s > MAX_COORD) s = MAX_COORD;
      return dtf_pkg::COORD_BITS'(s);
   endfunction

   function automatic dtf_pkg::box_type jitter_box(input dtf_pkg::box_type b, input int amt);
      dtf_pkg::box_type j;
      j.x = shift_coord(b.x, amt);
      j.y = shift_coord(b.y, amt);
      j.w = shift_coord(b.w, amt);
      j.h = shift_coord(b.h, amt);
      return j;
   endfunction

   function automatic dtf_pkg::box_type any_box(input int lo_len, input int hi_len);
      dtf_pkg::box_type b;
      b.x = dtf_pkg::COORD_BITS'($urandom_range(0, MAX_COORD));
      b.y = dtf_pkg::COORD_BITS'($urandom_range(0, MAX_COORD));
      b.w = dtf_pkg::COORD_BITS'($urandom_range(lo_len, hi_len));
      b.h = dtf_pkg::COORD_BITS'($urandom_range(lo_len, hi_len));
      return b;
   endfunction

   task automatic push_request(input logic func, input dtf_pkg::box_type b,
                               input logic [dtf_pkg::CLASS_BITS-1:0] cls, input logic tv);
      detection_req_type r;
      r.func = func;
      r.box = b;
      r.class_id = cls;
      r.trk_valid = tv;
      request_backlog.push_back(r);
      queued_total++;
   endtask

   task automatic push_box(input logic func, input int x, y, w, h, input int cls,
                           input logic tv);
      dtf_pkg::box_type b;
      b.x = dtf_pkg::COORD_BITS'(x);
      b.y = dtf_pkg::COORD_BITS'(y);
      b.w = dtf_pkg::COORD_BITS'(w);
      b.h = dtf_pkg::COORD_BITS'(h);
      push_request(func, b, dtf_pkg::CLASS_BITS'(cls), tv);
   endtask

   task automatic add_frame();
      int n, kind;
      dtf_pkg::box_type b;
      n = int'($urandom_range(0, 5));
      for (int i = 0; i < n; i++) begin
         kind = int'($urandom_range(0, 9));
         if (kind < 6) begin
            b = jitter_box(scene_box, 4);
         end else if (kind < 8) begin
            b = any_box(1, 400);
         end else begin
            b = any_box(0, MAX_COORD);
         end
         push_request(dtf_pkg::FUNC_DETECT, b,
                      ($urandom_range(0, 4) != 0) ? watch_class :
                      dtf_pkg::CLASS_BITS'($urandom_range(0, 255)),
                      $urandom_range(0, 1) != 0);
      end
      kind = int'($urandom_range(0, 9));
      if (kind < 6) begin
         b = jitter_box(scene_box, 2);
      end else if (kind < 8) begin
         b = any_box(1, 400);
      end else begin
         b = any_box(0, MAX_COORD);
      end
      push_request(dtf_pkg::FUNC_FRAME_END, b, dtf_pkg::CLASS_BITS'($urandom_range(0, 255)),
                   $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 15) == 0) begin
         scene_box = any_box(20, 400);
      end else begin
         scene_box = jitter_box(scene_box, 6);
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (accepted_total != queued_total || expected_rois.size() != 0);
   endtask

   task automatic write_target_class(input logic [dtf_pkg::CLASS_BITS-1:0] value);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      watch_class = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [dtf_pkg::CLASS_BITS-1:0] phase_class[4];
      int phase_start;
      phase_class[0] = 8'd255;
      phase_class[1] = dtf_pkg::CLASS_BITS'($urandom_range(1, 254));
      phase_class[2] = 8'd0;
      phase_class[3] = dtf_pkg::CLASS_BITS'($urandom_range(0, 255));
      scene_box = any_box(20, 400);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The tracker has never been started, so a valid tracker alone gives no region.
      push_box(dtf_pkg::FUNC_FRAME_END, 5, 6, 7, 8, 0, 1'b1);
      // A zero-area detection is never chosen while unlocked.
      push_box(dtf_pkg::FUNC_DETECT, 100, 100, 0, 50, 0, 1'b0);
      push_box(dtf_pkg::FUNC_FRAME_END, 0, 0, 0, 0, 0, 1'b1);
      // Equal areas keep the first box, and another class is ignored.
      push_box(dtf_pkg::FUNC_DETECT, 200, 300, 10, 10, 0, 1'b0);
      push_box(dtf_pkg::FUNC_DETECT, 400, 500, 20, 5, 0, 1'b1);
      push_box(dtf_pkg::FUNC_DETECT, 0, 0, MAX_COORD, MAX_COORD, 7, 1'b0);
      push_box(dtf_pkg::FUNC_FRAME_END, 0, 0, 1, 1, 0, 1'b1);
      // Locked: the nearest box wins and the overlapping tracker box is kept.
      push_box(dtf_pkg::FUNC_DETECT, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 0, 1'b1);
      push_box(dtf_pkg::FUNC_DETECT, 201, 300, 10, 10, 0, 1'b0);
      push_box(dtf_pkg::FUNC_DETECT, 0, 0, 0, 0, 0, 1'b0);
      push_box(dtf_pkg::FUNC_FRAME_END, 200, 300, 10, 10, 255, 1'b1);
      // No detection but a good tracker gives the tracker box.
      push_box(dtf_pkg::FUNC_FRAME_END, MAX_COORD, 0, MAX_COORD, MAX_COORD, 0, 1'b1);
      // Both boxes empty: the overlap test fails and the detection is taken.
      push_box(dtf_pkg::FUNC_DETECT, MAX_COORD, 0, 0, 0, 0, 1'b0);
      push_box(dtf_pkg::FUNC_FRAME_END, MAX_COORD, 0, 0, 0, 0, 1'b1);
      // Disjoint tracker box forces a restart on the detection.
      push_box(dtf_pkg::FUNC_DETECT, 1000, 1000, 50, 50, 0, 1'b0);
      push_box(dtf_pkg::FUNC_FRAME_END, 3000, 3000, 50, 50, 0, 1'b1);
      // No detection and a failed tracker gives no region.
      push_box(dtf_pkg::FUNC_FRAME_END, 1234, 2345, 345, 456, 255, 1'b0);
      // Equal distances keep the first box.
      push_box(dtf_pkg::FUNC_DETECT, 100, 2000, 20, 10, 0, 1'b0);
      push_box(dtf_pkg::FUNC_DETECT, 105, 2000, 10, 10, 0, 1'b1);
      push_box(dtf_pkg::FUNC_FRAME_END, 100, 2000, 20, 10, 0, 1'b0);

      for (int p = 0; p < 4; p++) begin
         write_target_class(phase_class[p]);
         phase_start = queued_total;
         while (queued_total - phase_start < PHASE_ITEMS) begin
            add_frame();
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            fuse_request(drive_item);
            accepted_total++;
         end
         if (idle_left > 0) begin
            idle_left--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            drive_item = request_backlog.pop_front();
            req_valid <= 1'b1;
            req_func <= drive_item.func;
            req_box_x <= drive_item.box.x;
            req_box_y <= drive_item.box.y;
            req_box_w <= drive_item.box.w;
            req_box_h <= drive_item.box.h;
            req_class_id <= drive_item.class_id;
            req_trk_valid <= drive_item.trk_valid;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = int'($urandom_range(0, 60));
               idle_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      dtf_pkg::res_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.roi.x = rsp_roi_x;
            got.roi.y = rsp_roi_y;
            got.roi.w = rsp_roi_w;
            got.roi.h = rsp_roi_h;
            got.success = rsp_success;
            got.reinit = rsp_reinit_tracker;
            if (expected_rois.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected response: roi %0d,%0d,%0d,%0d success %0b reinit %0b",
                           got.roi.x, got.roi.y, got.roi.w, got.roi.h, got.success,
                           got.reinit);
               end
            end else begin
               want = expected_rois.pop_front();
               if (got.roi.x !== want.roi.x || got.roi.y !== want.roi.y ||
                   got.roi.w !== want.roi.w || got.roi.h !== want.roi.h ||
                   got.success !== want.success || got.reinit !== want.reinit) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected roi %0d,%0d,%0d,%0d success %0b reinit %0b",
                              want.roi.x, want.roi.y, want.roi.w, want.roi.h, want.success,
                              want.reinit);
                     $display("          got      roi %0d,%0d,%0d,%0d success %0b reinit %0b",
                              got.roi.x, got.roi.y, got.roi.w, got.roi.h, got.success,
                              got.reinit);
                  end
               end
            end
         end
         if (stall_mode_left == 0) begin
            stall_mode = int'($urandom_range(0, 3));
            stall_mode_left = int'($urandom_range(20, 200));
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= cycle_count[2];
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

// File: filelist.f
hw/rtl/dtf_pkg.sv
hw/rtl/dtf_cand.sv
hw/rtl/dtf_decide.sv
hw/rtl/detection_tracker_fusion_core.sv
verif/testbench.sv
